/* rtl/core/svwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svwm_pkg
// Shared types, field widths and wave tables for the six-voice wavetable mixer.
// ----------------------------------------------------------------------------
package svwm_pkg;

	// Field widths of the input and result words.
	localparam int FUNC_W   = 2;
	localparam int VOICE_W  = 3;
	localparam int FREQ_W   = 17;
	localparam int VOLUME_W = 8;
	localparam int SAMPLE_W = 16;

	// Per-voice state widths.
	localparam int PHASE_W = 16;
	localparam int INCR_W  = 16;
	localparam int LEVEL_W = 8;

	localparam int NUM_VOICES_DEF = 6;

	// Wave tables. Every entry is either +FULL_SCALE or -FULL_SCALE.
	localparam int SQUARE_LEN = 64;
	localparam int NOISE_LEN  = 256;
	localparam int SQ_IDX_W   = $clog2(SQUARE_LEN);
	localparam int NZ_IDX_W   = $clog2(NOISE_LEN);
	localparam int IDX_LSB    = 8;

	// Mixing: level * FULL_SCALE, then an arithmetic shift right by MIX_SHIFT.
	localparam int FULL_SCALE_W = 15;
	localparam int MIX_SHIFT    = 11;
	localparam int MAG_W        = LEVEL_W + FULL_SCALE_W;
	localparam int TERM_W       = MAG_W - MIX_SHIFT + 2;
	localparam int SUM_W        = TERM_W + 3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SET   = 2'd0,
		FUNC_TICK  = 2'd1,
		FUNC_RESET = 2'd2
	} func_t;

	// Noise table: bit i of row r is set when entry 16*r+i is positive.
	localparam logic [15:0][15:0] NOISE_BITS = {
		16'h2BE5, 16'h7C23, 16'h2B65, 16'h7C23,
		16'h3A65, 16'h7C21, 16'h3865, 16'h7C65,
		16'h7C65, 16'h7465, 16'h7464, 16'h6464,
		16'h6444, 16'h4444, 16'h4000, 16'h0000
	};

	function automatic logic noise_positive(input logic [NZ_IDX_W-1:0] idx);
		logic [15:0] row;
		row = NOISE_BITS[idx[7:4]];
		return row[idx[3:0]];
	endfunction

	function automatic logic square_positive(input logic [SQ_IDX_W-1:0] idx);
		return idx < SQ_IDX_W'(SQUARE_LEN / 2);
	endfunction

endpackage
`default_nettype wire

/* rtl/core/six_voice_wavetable_mixer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// six_voice_wavetable_mixer_core
// Phase-accumulator wavetable sound generator with a mixed 16-bit output.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle and returns one signed
// 16-bit sample for every tick word. The tick word is taken into the input
// register and its sample then into the sample register; the tick word waits
// while the sample register is still held by out_stall.
// A set word loads one voice's volume and phase increment (frequency shifted
// right by one), a reset word clears all volumes and increments while the
// phases keep running, and a tick word mixes all voices into a sample and
// then advances every phase. Set and reset words, and the unused function
// code, give no sample. The rate is one word per cycle, set by the single
// execute stage that sits between the input register and the sample
// register; when the sample register is held by out_stall, the next tick
// word waits in the input register and in_stall rises.
// ----------------------------------------------------------------------------
module six_voice_wavetable_mixer_core #(
	parameter int NUM_VOICES = svwm_pkg::NUM_VOICES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic [svwm_pkg::FUNC_W-1:0]         func,
	input  wire logic [svwm_pkg::VOICE_W-1:0]        voice,
	input  wire logic [svwm_pkg::FREQ_W-1:0]         freq,
	input  wire logic [svwm_pkg::VOLUME_W-1:0]       volume,

	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic signed [svwm_pkg::SAMPLE_W-1:0] sample
);

	localparam int VW     = svwm_pkg::VOICE_W;
	localparam int MAG_W  = svwm_pkg::MAG_W;
	localparam int TERM_W = svwm_pkg::TERM_W;
	localparam int SUM_W  = svwm_pkg::SUM_W;
	localparam int SHIFT  = svwm_pkg::MIX_SHIFT;
	localparam int FS_W   = svwm_pkg::FULL_SCALE_W;
	localparam int LSB    = svwm_pkg::IDX_LSB;

	// Input register: holds one word until the execute stage can retire it.
	logic                              s1_valid_s1;
	svwm_pkg::func_t                   func_s1;
	logic [VW-1:0]                     voice_s1;
	logic [svwm_pkg::FREQ_W-1:0]       freq_s1;
	logic [svwm_pkg::VOLUME_W-1:0]     volume_s1;

	// Voice state.
	logic [svwm_pkg::PHASE_W-1:0] phase_q [NUM_VOICES];
	logic [svwm_pkg::INCR_W-1:0]  incr_q  [NUM_VOICES];
	logic [svwm_pkg::LEVEL_W-1:0] level_q [NUM_VOICES];

	// Sample register.
	logic                                 out_valid_q;
	logic signed [svwm_pkg::SAMPLE_W-1:0] sample_q;

	logic                       in_fire;
	logic                       out_free;
	logic                       s1_fire;
	logic                       tick_fire;
	logic                       set_fire;
	logic                       clr_fire;
	logic signed [TERM_W-1:0]   term [NUM_VOICES];
	logic signed [SUM_W-1:0]    mix_sum;
	logic                       any_level;

	// The sample register frees up when it is empty or being read this cycle.
	assign out_free = !out_valid_q || !out_stall;

	// Only a tick word needs room in the sample register; the others retire
	// at once.
	assign s1_fire   = s1_valid_s1 && ((func_s1 != svwm_pkg::FUNC_TICK) || out_free);
	assign tick_fire = s1_fire && (func_s1 == svwm_pkg::FUNC_TICK);
	assign set_fire  = s1_fire && (func_s1 == svwm_pkg::FUNC_SET);
	assign clr_fire  = s1_fire && (func_s1 == svwm_pkg::FUNC_RESET);

	assign in_stall = s1_valid_s1 && !s1_fire;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1   <= svwm_pkg::func_t'(func);
			voice_s1  <= voice;
			freq_s1   <= freq;
			volume_s1 <= volume;
		end
	end

	// Per-voice contribution: floor(level * (+/-32767) / 2048). The product
	// with 32767 is formed as (level << 15) - level, and the negative case
	// uses an arithmetic shift of the negated magnitude, which rounds toward
	// minus infinity.
	for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
		logic [MAG_W-1:0]        mag;
		logic signed [MAG_W:0]   neg_mag;
		logic signed [MAG_W:0]   neg_shr;
		logic                    positive;

		assign mag     = {level_q[v], FS_W'(0)} - MAG_W'(level_q[v]);
		assign neg_mag = -$signed({1'b0, mag});
		assign neg_shr = neg_mag >>> SHIFT;

		if (v < NUM_VOICES / 2) begin : g_square
			assign positive = svwm_pkg::square_positive(
				phase_q[v][LSB +: svwm_pkg::SQ_IDX_W]);
		end else begin : g_noise
			assign positive = svwm_pkg::noise_positive(
				phase_q[v][LSB +: svwm_pkg::NZ_IDX_W]);
		end

		assign term[v] = positive ? $signed({2'b00, mag[MAG_W-1:SHIFT]})
		                          : neg_shr[TERM_W-1:0];
	end

	always_comb begin
		mix_sum = '0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			mix_sum = mix_sum + SUM_W'(term[v]);
		end
	end

	// Voice state updates. A set word for a voice number past the last voice
	// matches no entry and so changes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				phase_q[v] <= '0;
				incr_q[v]  <= '0;
				level_q[v] <= '0;
			end
		end else begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				if (tick_fire) begin
					phase_q[v] <= phase_q[v] + incr_q[v];
				end
				if (clr_fire) begin
					incr_q[v]  <= '0;
					level_q[v] <= '0;
				end else if (set_fire && (voice_s1 == VW'(v))) begin
					incr_q[v]  <= freq_s1[svwm_pkg::FREQ_W-1:1];
					level_q[v] <= volume_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			sample_q <= mix_sum[svwm_pkg::SAMPLE_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	always_comb begin
		any_level = 1'b0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			any_level = any_level | (|level_q[v]);
		end
	end

	// A tick word that leaves the execute stage always lands in the sample
	// register.
	a_tick_lands: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> out_valid_q)
		else $error("tick word retired without a sample");

	// The input side only stalls while a word sits in the input register.
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_s1 |-> !in_stall)
		else $error("input stalled with an empty input register");

	// A held sample is never overwritten by a new tick.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !tick_fire)
		else $error("sample register overwritten while stalled");

	// After a reset word every volume is zero.
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr_fire |=> !any_level)
		else $error("reset word left a voice volume set");

endmodule
`default_nettype wire
